// ----- design/postfix_regex_to_nfa_builder_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the postfix regex to NFA builder.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_REGEX_TO_NFA_BUILDER_DEFINES_SVH
`define POSTFIX_REGEX_TO_NFA_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define PRNB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRNB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PRNB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PRNB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/prnb_pkg.sv -----
// ----------------------------------------------------------------------------
// prnb_pkg
// Types, symbol codes and fault codes of the postfix regex to NFA builder.
// ----------------------------------------------------------------------------
package prnb_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POP1,
        ST_POP2,
        ST_LOAD,
        ST_FIN,
        ST_FIN2,
        ST_EMIT
    } t_state;

    // Kind of postfix symbol.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LIT,
        OP_CAT,
        OP_ALT,
        OP_STAR,
        OP_QUEST,
        OP_PLUS
    } t_op;

    localparam logic [7:0] SYM_EPS   = 8'h24;
    localparam logic [7:0] SYM_CAT   = 8'h2E;
    localparam logic [7:0] SYM_ALT   = 8'h7C;
    localparam logic [7:0] SYM_STAR  = 8'h2A;
    localparam logic [7:0] SYM_QUEST = 8'h3F;
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_NULL  = 8'h00;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_UNDER = 2'd1;
    localparam logic [1:0] FAULT_OVER  = 2'd2;
    localparam logic [1:0] FAULT_FULL  = 2'd3;

    // One result item as held in the output register.
    typedef struct packed {
        logic [7:0] state_id;
        logic [7:0] transform;
        logic [7:0] next_first;
        logic [7:0] next_second;
        logic       accepting;
        logic       run_end;
        logic [7:0] nfa_start;
        logic       finished;
        logic [1:0] fault;
    } t_rec;

    function automatic t_op op_decode(input logic [7:0] sym);
        t_op op;
        case (sym)
            SYM_NULL:  op = OP_NONE;
            SYM_CAT:   op = OP_CAT;
            SYM_ALT:   op = OP_ALT;
            SYM_STAR:  op = OP_STAR;
            SYM_QUEST: op = OP_QUEST;
            SYM_PLUS:  op = OP_PLUS;
            default:   op = OP_LIT;
        endcase
        return op;
    endfunction

endpackage

// ----- design/prnb_sym_if.sv -----
// ----------------------------------------------------------------------------
// prnb_sym_if
// Input channel: one postfix symbol per transfer.
// ----------------------------------------------------------------------------
interface prnb_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ----- design/prnb_rec_if.sv -----
// ----------------------------------------------------------------------------
// prnb_rec_if
// Output channel: one NFA state record per transfer.
// ----------------------------------------------------------------------------
interface prnb_rec_if;
    logic       valid;
    logic       ready;
    logic [7:0] state_id;
    logic [7:0] transform;
    logic [7:0] next_first;
    logic [7:0] next_second;
    logic       accepting;
    logic       run_end;
    logic [7:0] nfa_start;
    logic       finished;
    logic [1:0] fault;

    modport source (
        output valid, output state_id, output transform, output next_first,
        output next_second, output accepting, output run_end, output nfa_start,
        output finished, output fault, input ready
    );
    modport sink (
        input valid, input state_id, input transform, input next_first,
        input next_second, input accepting, input run_end, input nfa_start,
        input finished, input fault, output ready
    );
endinterface

// ----- design/postfix_regex_to_nfa_builder.sv -----
// ----------------------------------------------------------------------------
// postfix_regex_to_nfa_builder
// Thompson construction of an NFA from a postfix regular expression.
// ----------------------------------------------------------------------------
// The block takes one postfix symbol per input transfer and reports every NFA
// state record that the symbol writes, one record per output transfer, with
// run_end on the last record of the symbol. A small sequencer handles one
// symbol at a time and is not ready while it works: it checks the symbol,
// pops up to two fragments from the fragment stack through its single read
// port, builds and pushes the new fragment, pops the finished NFA on a symbol
// marked last, and then emits the records through the output register. The
// output register lets the next symbol be taken while the final record still
// waits for its transfer. Every record is fully rewritten when it is reported,
// so its contents come straight from the fragment registers and the state
// table never needs to be read back. Faults are checked in order underflow,
// overflow, table full.
// ----------------------------------------------------------------------------
`include "postfix_regex_to_nfa_builder_defines.svh"

module postfix_regex_to_nfa_builder #(
    parameter int MAX_STATES  = 255,
    parameter int STACK_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prnb_sym_if.sink    i_sym,
    prnb_rec_if.source  o_rec
);
    import prnb_pkg::*;

    localparam int IW = $clog2(MAX_STATES + 1);   // stored state number
    localparam int NW = $clog2(MAX_STATES + 2);   // state counter, holds MAX+1
    localparam int CW = $clog2(STACK_DEPTH + 1);  // stack fill count
    localparam int AW = $clog2(STACK_DEPTH);      // stack address

    // Control registers.
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [NW-1:0]   r_next, n_next;
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_k, n_k;

    // Working registers of the current symbol.
    logic [7:0]      r_sym, n_sym;
    logic            r_last, n_last;
    t_op             r_op, n_op;
    logic            r_act, n_act;
    logic [1:0]      r_fault, n_fault;
    logic [NW-1:0]   r_sum, n_sum;
    logic [IW-1:0]   r_s1, n_s1, r_a1, n_a1, r_s2, n_s2, r_a2, n_a2;
    logic [IW-1:0]   r_ns, n_ns, r_na, n_na, r_nfa, n_nfa;
    t_rec            r_out, n_out;

    // Fragment stack: {start, accept} per entry.
    logic [2*IW-1:0] r_stack [STACK_DEPTH];
    logic [2*IW-1:0] r_rd_data;
    logic [AW-1:0]   w_rd_addr, w_wr_addr;
    logic [2*IW-1:0] w_wr_data;
    logic            w_wr_en;

    // Decoded symbol and the shared state-number adder.
    logic [1:0]      w_npop, w_nnew, w_last_k;
    logic [NW:0]     w_sum;
    logic            w_full;
    logic [1:0]      w_fault;
    logic            w_act;
    logic [CW-1:0]   w_cnt_m1, w_cnt_m2, w_cnt_base;
    logic [NW-1:0]   w_na_full;
    logic            w_load, w_end;
    t_rec            w_rec;

    function automatic logic [7:0] lo8(input logic [IW-1:0] v);
        logic [IW+7:0] w;
        w = {8'd0, v};
        return w[7:0];
    endfunction

    // Pops, new states and last record index of each kind of symbol.
    always_comb begin
        case (r_op)
            OP_LIT:   begin w_npop = 2'd0; w_nnew = 2'd2; w_last_k = 2'd1; end
            OP_CAT:   begin w_npop = 2'd2; w_nnew = 2'd0; w_last_k = 2'd0; end
            OP_ALT:   begin w_npop = 2'd2; w_nnew = 2'd2; w_last_k = 2'd3; end
            OP_STAR,
            OP_QUEST: begin w_npop = 2'd1; w_nnew = 2'd2; w_last_k = 2'd2; end
            OP_PLUS:  begin w_npop = 2'd1; w_nnew = 2'd1; w_last_k = 2'd1; end
            default:  begin w_npop = 2'd0; w_nnew = 2'd0; w_last_k = 2'd0; end
        endcase
    end

    // Admission check of the symbol, in priority order.
    always_comb begin
        w_sum  = {1'b0, r_next} + (NW+1)'(w_nnew);
        w_full = w_sum > (NW+1)'(MAX_STATES + 1);
        w_act  = 1'b0;
        if (r_op == OP_NONE) begin
            w_fault = FAULT_NONE;
        end else if (r_count < CW'(w_npop)) begin
            w_fault = FAULT_UNDER;
        end else if (w_npop == 2'd0 && r_count >= CW'(STACK_DEPTH)) begin
            w_fault = FAULT_OVER;
        end else if (w_full) begin
            w_fault = FAULT_FULL;
        end else begin
            w_fault = FAULT_NONE;
            w_act   = 1'b1;
        end
    end

    assign w_cnt_m1   = r_count - CW'(1);
    assign w_cnt_m2   = r_count - CW'(2);
    assign w_cnt_base = r_count - CW'(w_npop);
    assign w_na_full  = r_sum - NW'(1);
    assign w_rd_addr  = (r_state == ST_POP2) ? w_cnt_m2[AW-1:0] : w_cnt_m1[AW-1:0];
    assign w_wr_addr  = w_cnt_base[AW-1:0];

    assign w_load = (r_state == ST_EMIT) && (!r_out_valid || o_rec.ready);
    assign w_end  = !r_act || (r_k == w_last_k);

    // Record number r_k of the current symbol.
    always_comb begin
        w_rec = '0;
        if (r_act) begin
            case (r_op)
                OP_LIT: begin
                    if (r_k == 2'd0) begin
                        w_rec.state_id   = lo8(r_ns);
                        w_rec.transform  = r_sym;
                        w_rec.next_first = lo8(r_na);
                    end else begin
                        w_rec.state_id   = lo8(r_na);
                        w_rec.accepting  = 1'b1;
                    end
                end
                OP_CAT: begin
                    w_rec.state_id   = lo8(r_a1);
                    w_rec.transform  = SYM_EPS;
                    w_rec.next_first = lo8(r_s2);
                end
                OP_ALT: begin
                    if (r_k == 2'd0) begin
                        w_rec.state_id   = lo8(r_a1);
                        w_rec.transform  = SYM_EPS;
                        w_rec.next_first = lo8(r_na);
                    end else if (r_k == 2'd1) begin
                        w_rec.state_id   = lo8(r_a2);
                        w_rec.transform  = SYM_EPS;
                        w_rec.next_first = lo8(r_na);
                    end else if (r_k == 2'd2) begin
                        w_rec.state_id    = lo8(r_ns);
                        w_rec.transform   = SYM_EPS;
                        w_rec.next_first  = lo8(r_s1);
                        w_rec.next_second = lo8(r_s2);
                    end else begin
                        w_rec.state_id  = lo8(r_na);
                        w_rec.accepting = 1'b1;
                    end
                end
                OP_STAR, OP_QUEST: begin
                    if (r_k == 2'd0) begin
                        w_rec.state_id    = lo8(r_a1);
                        w_rec.transform   = SYM_EPS;
                        w_rec.next_first  = lo8(r_na);
                        w_rec.next_second = (r_op == OP_STAR) ? lo8(r_s1) : 8'd0;
                    end else if (r_k == 2'd1) begin
                        w_rec.state_id    = lo8(r_ns);
                        w_rec.transform   = SYM_EPS;
                        w_rec.next_first  = lo8(r_s1);
                        w_rec.next_second = lo8(r_na);
                    end else begin
                        w_rec.state_id  = lo8(r_na);
                        w_rec.accepting = 1'b1;
                    end
                end
                OP_PLUS: begin
                    if (r_k == 2'd0) begin
                        w_rec.state_id   = lo8(r_a1);
                        w_rec.transform  = SYM_EPS;
                        w_rec.next_first = lo8(r_na);
                    end else begin
                        w_rec.state_id   = lo8(r_na);
                        w_rec.transform  = SYM_EPS;
                        w_rec.next_first = lo8(r_s1);
                        w_rec.accepting  = 1'b1;
                    end
                end
                default: w_rec = '0;
            endcase
        end
        w_rec.run_end   = w_end;
        w_rec.nfa_start = (w_end && r_last) ? lo8(r_nfa) : 8'd0;
        w_rec.finished  = w_end && r_last;
        w_rec.fault     = w_end ? r_fault : FAULT_NONE;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_sym.valid) n_state = ST_CHECK;
            ST_CHECK: begin
                if (!w_act) begin
                    n_state = ST_FIN;
                end else if (w_npop != 2'd0) begin
                    n_state = ST_POP1;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            ST_POP1:  n_state = (w_npop == 2'd2) ? ST_POP2 : ST_LOAD;
            ST_POP2:  n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_FIN;
            ST_FIN: begin
                if (r_last && r_count != '0) begin
                    n_state = ST_FIN2;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_FIN2:  n_state = ST_EMIT;
            ST_EMIT:  if (w_load && w_end) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_count     = r_count;
        n_next      = r_next;
        n_k         = r_k;
        n_sym       = r_sym;
        n_last      = r_last;
        n_op        = r_op;
        n_act       = r_act;
        n_fault     = r_fault;
        n_sum       = r_sum;
        n_s1        = r_s1;
        n_a1        = r_a1;
        n_s2        = r_s2;
        n_a2        = r_a2;
        n_ns        = r_ns;
        n_na        = r_na;
        n_nfa       = r_nfa;
        n_out       = r_out;
        n_out_valid = (r_out_valid && o_rec.ready) ? 1'b0 : r_out_valid;
        w_wr_en     = 1'b0;
        w_wr_data   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_sym.valid) begin
                    n_sym   = i_sym.symbol;
                    n_last  = i_sym.last;
                    n_op    = op_decode(i_sym.symbol);
                    n_k     = 2'd0;
                    n_nfa   = '0;
                end
            end
            ST_CHECK: begin
                n_fault = w_fault;
                n_act   = w_act;
                n_sum   = w_sum[NW-1:0];
            end
            ST_POP2: begin
                n_s2 = r_rd_data[2*IW-1:IW];
                n_a2 = r_rd_data[IW-1:0];
            end
            ST_LOAD: begin
                n_s1    = r_rd_data[2*IW-1:IW];
                n_a1    = r_rd_data[IW-1:0];
                n_ns    = r_next[IW-1:0];
                n_na    = w_na_full[IW-1:0];
                n_next  = r_sum;
                n_count = w_cnt_base + CW'(1);
                w_wr_en = 1'b1;
                case (r_op)
                    OP_CAT:  w_wr_data = {r_rd_data[2*IW-1:IW], r_a2};
                    OP_PLUS: w_wr_data = {r_rd_data[2*IW-1:IW], w_na_full[IW-1:0]};
                    default: w_wr_data = {r_next[IW-1:0], w_na_full[IW-1:0]};
                endcase
            end
            ST_FIN: begin
                if (r_last) begin
                    if (r_count == '0) begin
                        n_nfa = '0;
                        if (r_fault == FAULT_NONE) n_fault = FAULT_UNDER;
                    end else begin
                        n_count = w_cnt_m1;
                    end
                end
            end
            ST_FIN2: begin
                n_nfa = r_rd_data[2*IW-1:IW];
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_out       = w_rec;
                    n_out_valid = 1'b1;
                    n_k         = r_k + 2'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_next      <= NW'(1);
            r_out_valid <= 1'b0;
            r_k         <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym   <= n_sym;
        r_last  <= n_last;
        r_op    <= n_op;
        r_act   <= n_act;
        r_fault <= n_fault;
        r_sum   <= n_sum;
        r_s1    <= n_s1;
        r_a1    <= n_a1;
        r_s2    <= n_s2;
        r_a2    <= n_a2;
        r_ns    <= n_ns;
        r_na    <= n_na;
        r_nfa   <= n_nfa;
        r_out   <= n_out;
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_stack[w_wr_addr] <= w_wr_data;
        r_rd_data <= r_stack[w_rd_addr];
    end

    assign i_sym.ready       = (r_state == ST_IDLE);
    assign o_rec.valid       = r_out_valid;
    assign o_rec.state_id    = r_out.state_id;
    assign o_rec.transform   = r_out.transform;
    assign o_rec.next_first  = r_out.next_first;
    assign o_rec.next_second = r_out.next_second;
    assign o_rec.accepting   = r_out.accepting;
    assign o_rec.run_end     = r_out.run_end;
    assign o_rec.nfa_start   = r_out.nfa_start;
    assign o_rec.finished    = r_out.finished;
    assign o_rec.fault       = r_out.fault;

    // The fill count never passes the stack depth.
    `PRNB_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(STACK_DEPTH))
    // The state counter stops at one past the last table entry.
    `PRNB_ASSERT_IMPL(a_next_bound, i_clk, i_rst_n, 1'b1, r_next <= NW'(MAX_STATES + 1))
    // The record that closes an expression is also the last one of its symbol.
    `PRNB_ASSERT_IMPL(a_finish_end, i_clk, i_rst_n, o_rec.valid && o_rec.finished, o_rec.run_end)
    // A taken symbol keeps the block busy in the following cycle.
    `PRNB_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_sym.valid && i_sym.ready, !i_sym.ready)

endmodule
